FILE: design/lgs_pkg.sv
// Package for the life generation step block: field widths, action and
// register codes, rule constants and the control word broadcast to the row cells.
// No dependencies.
package lgs_pkg;

  localparam int ACTION_W   = 2;
  localparam int X_W        = 6;
  localparam int Y_W        = 5;
  localparam int CNT_W      = 4;
  localparam int GW_W       = 7;
  localparam int GH_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Item actions.
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [GW_W-1:0] GW_RESET = 7'd40;
  localparam logic [GH_W-1:0] GH_RESET = 6'd20;
  localparam logic [GW_W-1:0] MIN_W    = 7'd3;
  localparam logic [GH_W-1:0] MIN_H    = 6'd3;

  // B3/S23: a dead cell with three neighbors is born, a live one with two or
  // three survives.
  localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic            shift;   // rotate the active ring by one row toward cell 0
    logic            fix0;    // load cell 0 from the fix bus
    logic            wr_en;   // single cell write
    logic            wr_val;
    logic [X_W-1:0]  wr_x;
    logic [Y_W-1:0]  wr_y;
    logic [GH_W-1:0] h;       // rows in use
  } cell_ctrl_t;

endpackage

FILE: design/lgs_if.sv
// Handshake channels of the life generation step block: request items,
// result items and configuration writes. Depends on lgs_pkg.
interface lgs_req_if import lgs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [X_W-1:0]      x;
  logic [Y_W-1:0]      y;
  logic                alive;

  modport source(output valid, output action, output x, output y, output alive,
                 input ready);
  modport sink(input valid, input action, input x, input y, input alive,
               output ready);
endinterface

interface lgs_rsp_if import lgs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cell_alive;
  logic [CNT_W-1:0] neighbor_count;

  modport source(output valid, output cell_alive, output neighbor_count,
                 input ready);
  modport sink(input valid, input cell_alive, input neighbor_count,
               output ready);
endinterface

interface lgs_cfg_if import lgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/lgs_row_cell.sv
// One row cell of the board ring: holds a single row and takes its right
// neighbor's row when the ring rotates. Depends on lgs_pkg.
module lgs_row_cell import lgs_pkg::*; #(
  parameter int ROW_W = 64,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [ROW_W-1:0] next_row,
  input  logic [ROW_W-1:0] push_row,
  input  logic [ROW_W-1:0] fix_row,
  output logic [ROW_W-1:0] row
);

  localparam int XI = (ROW_W > 1) ? $clog2(ROW_W) : 1;

  logic active;
  logic is_tail;
  logic wr_hit;

  // Only the rows in use form the ring; the last of them takes the pushed row.
  assign active  = IDX < int'(ctrl.h);
  assign is_tail = IDX == int'(ctrl.h) - 1;
  assign wr_hit  = ctrl.wr_en && (IDX == int'(ctrl.wr_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      priority if (ctrl.shift && active) begin
        row <= is_tail ? push_row : next_row;
      end else if (ctrl.fix0 && IDX == 0) begin
        row <= fix_row;
      end else if (wr_hit) begin
        row[ctrl.wr_x[XI-1:0]] <= ctrl.wr_val;
      end else begin
        row <= row;
      end
    end
  end

endmodule

FILE: design/lgs_rule_unit.sv
// Row-wide B3/S23 rule: the next state of one row from the rows above and
// below, with wrap at the width in use. Depends on lgs_pkg.
module lgs_rule_unit import lgs_pkg::*; #(
  parameter int ROW_W = 64
) (
  input  logic [ROW_W-1:0] up,
  input  logic [ROW_W-1:0] mid,
  input  logic [ROW_W-1:0] dn,
  input  logic [GW_W-1:0]  w,
  output logic [ROW_W-1:0] next_row
);

  localparam int XI = (ROW_W > 1) ? $clog2(ROW_W) : 1;

  logic [XI-1:0] last;
  logic          up_last;
  logic          mid_last;
  logic          dn_last;

  assign last     = XI'(w - 7'd1);
  assign up_last  = up[last];
  assign mid_last = mid[last];
  assign dn_last  = dn[last];

  for (genvar i = 0; i < ROW_W; i++) begin : g_col
    logic             ul, ml, dl, ur, mr, dr;
    logic [CNT_W-1:0] n;

    if (i == 0) begin : g_left_wrap
      assign ul = up_last;
      assign ml = mid_last;
      assign dl = dn_last;
    end else begin : g_left
      assign ul = up[i-1];
      assign ml = mid[i-1];
      assign dl = dn[i-1];
    end

    if (i == ROW_W - 1) begin : g_right_wrap
      assign ur = up[0];
      assign mr = mid[0];
      assign dr = dn[0];
    end else begin : g_right
      logic wrap_r;
      assign wrap_r = (GW_W'(i + 1) == w);
      assign ur = wrap_r ? up[0] : up[i+1];
      assign mr = wrap_r ? mid[0] : mid[i+1];
      assign dr = wrap_r ? dn[0] : dn[i+1];
    end

    assign n = CNT_W'(ul) + CNT_W'(up[i]) + CNT_W'(ur) + CNT_W'(ml) + CNT_W'(mr)
             + CNT_W'(dl) + CNT_W'(dn[i]) + CNT_W'(dr);

    // Columns beyond the width in use keep their value.
    assign next_row[i] = (GW_W'(i) < w)
                       ? ((n == BIRTH_COUNT) || (mid[i] && (n == SURVIVE_COUNT)))
                       : mid[i];
  end

endmodule

FILE: design/life_generation_step.sv
// Life generation step, B3/S23 on a toroidal board held in a ring of row cells.
// A write leaves the block idle. A read sweeps the h rows of the ring, or skips
// the sweep outside the area, and the next item is taken once its result is
// loaded; an advance rotates the ring and then loads cell 0. h is the row count
// in use (3..32). A read also waits while an earlier result is not taken.
// Synchronous reset clears the board to dead, sets width 40 and height 20.
module life_generation_step import lgs_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32
) (
  input  logic       clk,
  input  logic       rst,
  lgs_req_if.sink    req,
  lgs_rsp_if.source  rsp,
  lgs_cfg_if.sink    cfg
);

  // The board lives in MAX_HEIGHT row cells. Cell i holds row i. The first h
  // cells form a ring: on a shift every cell takes the row of its right
  // neighbor and cell h-1 takes the pushed row, so rows leave through cell 0
  // (the head) in the order 0, 1, ..., h-1.
  //
  // A read rotates the ring h times with the head pushed straight back, which
  // leaves the board in place, and catches rows y-1, y and y+1 as they pass.
  //
  // An advance rotates h+1 times. The first two rows are saved; from the third
  // shift on, the rule unit sees rows t-2, t-1 and t and pushes the new row
  // t-1. When the ring runs out, the saved rows 0 and 1 stand in for the wrap.
  // After the last shift cells 1..h-1 hold their new rows; the new row 0 is then
  // computed from rows h-1, 0 and 1 and loaded into cell 0.

  localparam int ROW_W = MAX_WIDTH;
  localparam int XI    = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int HCAP  = (MAX_HEIGHT < 63) ? MAX_HEIGHT : 63;
  localparam int T_W   = GH_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_STEP   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers and the saturated sizes in use.
  logic [GW_W-1:0] grid_width;
  logic [GH_W-1:0] grid_height;
  logic [GW_W-1:0] w_use;
  logic [GH_W-1:0] h_use;
  logic [T_W-1:0]  h_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GW_RESET;
      grid_height <= GH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_GRID_WIDTH:  grid_width  <= cfg.data[GW_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg.data[GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (grid_width < MIN_W) begin
      w_use = MIN_W;
    end else if (grid_width > GW_W'(MAX_WIDTH)) begin
      w_use = GW_W'(MAX_WIDTH);
    end else begin
      w_use = grid_width;
    end
    priority if (grid_height < MIN_H) begin
      h_use = MIN_H;
    end else if (grid_height > GH_W'(HCAP)) begin
      h_use = GH_W'(HCAP);
    end else begin
      h_use = grid_height;
    end
  end

  assign h_ext = T_W'(h_use);

  // Request side. One item is handled at a time.
  logic req_fire;
  logic in_area;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign in_area   = (GW_W'(req.x) < w_use) && (GH_W'(req.y) < h_use);

  // Sweep step counter and row registers.
  logic [T_W-1:0]   t;
  logic [ROW_W-1:0] rows [MAX_HEIGHT];
  logic [ROW_W-1:0] head;
  logic [ROW_W-1:0] push_row;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] rule_row;
  logic [ROW_W-1:0] save0, save1;
  logic [ROW_W-1:0] win_a, win_b;
  cell_ctrl_t       ctrl;

  assign head = rows[0];

  always_comb begin
    ctrl.shift  = (state == ST_READ) || ((state == ST_STEP) && (t <= h_ext));
    ctrl.fix0   = (state == ST_STEP) && (t == h_ext + T_W'(1));
    ctrl.wr_en  = req_fire && (req.action == ACT_WRITE) && in_area;
    ctrl.wr_val = req.alive;
    ctrl.wr_x   = req.x;
    ctrl.wr_y   = req.y;
    ctrl.h      = h_use;
  end

  // Once the ring is exhausted the saved first rows supply the wrap.
  always_comb begin
    priority if (t < h_ext) begin
      cur_row = head;
    end else if (t == h_ext) begin
      cur_row = save0;
    end else begin
      cur_row = save1;
    end
  end

  assign push_row = ((state == ST_STEP) && (t >= T_W'(2))) ? rule_row : head;

  lgs_rule_unit #(.ROW_W(ROW_W)) u_rule (
    .up       (win_a),
    .mid      (win_b),
    .dn       (cur_row),
    .w        (w_use),
    .next_row (rule_row)
  );

  for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_cell
    logic [ROW_W-1:0] right_row;
    if (i == MAX_HEIGHT - 1) begin : g_end
      assign right_row = push_row;
    end else begin : g_mid
      assign right_row = rows[i+1];
    end
    lgs_row_cell #(.ROW_W(ROW_W), .IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .next_row (right_row),
      .push_row (push_row),
      .fix_row  (rule_row),
      .row      (rows[i])
    );
  end

  // Read bookkeeping: coordinates and the three rows caught during the sweep.
  logic [X_W-1:0]   rd_x;
  logic [GH_W-1:0]  rd_y, rd_ym1, rd_yp1;
  logic             rd_zero;
  logic [ROW_W-1:0] up_row, mid_row, dn_row;
  logic             res_load;
  logic             out_valid;

  assign res_load = (state == ST_RESULT) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      t     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          t <= '0;
          if (req_fire) begin
            unique case (req.action)
              ACT_READ:    state <= in_area ? ST_READ : ST_RESULT;
              ACT_ADVANCE: state <= ST_STEP;
              default: ;
            endcase
          end
        end
        ST_READ: begin
          t <= t + T_W'(1);
          if (t == h_ext - T_W'(1)) begin
            state <= ST_RESULT;
          end
        end
        ST_STEP: begin
          t <= t + T_W'(1);
          if (ctrl.fix0) begin
            state <= ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && (req.action == ACT_READ)) begin
      rd_x    <= req.x;
      rd_y    <= GH_W'(req.y);
      rd_ym1  <= (req.y == '0) ? h_use - GH_W'(1) : GH_W'(req.y) - GH_W'(1);
      rd_yp1  <= (GH_W'(req.y) + GH_W'(1) == h_use) ? '0 : GH_W'(req.y) + GH_W'(1);
      rd_zero <= !in_area;
    end
    if (state == ST_READ) begin
      if (t == T_W'(rd_ym1)) up_row  <= head;
      if (t == T_W'(rd_y))   mid_row <= head;
      if (t == T_W'(rd_yp1)) dn_row  <= head;
    end
    if (state == ST_STEP) begin
      if (t == T_W'(0)) save0 <= head;
      if (t == T_W'(1)) save1 <= head;
      win_a <= win_b;
      win_b <= cur_row;
    end
  end

  // Neighbor count of the read cell, with wrap at the width in use.
  logic [XI-1:0]    xi, xm1, xp1;
  logic [CNT_W-1:0] rd_count;

  assign xi  = rd_x[XI-1:0];
  assign xm1 = (rd_x == '0) ? XI'(w_use - GW_W'(1)) : XI'(rd_x - X_W'(1));
  assign xp1 = (GW_W'(rd_x) + GW_W'(1) == w_use) ? '0 : XI'(GW_W'(rd_x) + GW_W'(1));

  assign rd_count = CNT_W'(up_row[xm1]) + CNT_W'(up_row[xi]) + CNT_W'(up_row[xp1])
                  + CNT_W'(mid_row[xm1]) + CNT_W'(mid_row[xp1])
                  + CNT_W'(dn_row[xm1]) + CNT_W'(dn_row[xi]) + CNT_W'(dn_row[xp1]);

  // Output register: holds the result item until it is taken.
  logic             out_alive;
  logic [CNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_alive <= rd_zero ? 1'b0 : mid_row[xi];
      out_count <= rd_zero ? '0 : rd_count;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.cell_alive     = out_alive;
  assign rsp.neighbor_count = out_count;

  // A result item only appears after a read has reached the result stage.
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RESULT))
    else $error("result item without a finished read");

  // An advance never runs past its final cell-0 load.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (t <= h_ext + T_W'(1)))
    else $error("advance sweep counter overran");

  // The final cell-0 load ends the advance.
  a_step_ends: assert property (@(posedge clk) disable iff (rst)
    ctrl.fix0 |=> (state == ST_IDLE))
    else $error("advance did not return to idle");

  // A read sweep hands over to the result stage after h rotations.
  a_read_len: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_READ) && (t == h_ext - T_W'(1))) |=> (state == ST_RESULT))
    else $error("read sweep length wrong");

endmodule

FILE: sim/testbench.sv
// Testbench for life_generation_step: random and directed cell writes, reads and
// generation steps, checked against a board-level predictor of the B3/S23 rule.
// Depends on lgs_pkg, the lgs_*_if interfaces and the life_generation_step RTL.
module testbench;
  import lgs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action code that the block must ignore without a result.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // The worst read or advance sweeps 32 rows. Allow some slack beyond that.
  localparam int SETTLE_CYCLES  = 48;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 200;

  typedef struct {
    logic             cell_alive;
    logic [CNT_W-1:0] neighbor_count;
  } cell_report_t;

  // Keeps its own copy of the board and the size registers. It predicts the
  // result of each read and checks what the block returns.
  class life_board_predictor;
    bit [63:0]     board [32];
    bit [GW_W-1:0] grid_width;
    bit [GH_W-1:0] grid_height;
    cell_report_t  pending_reads [$];
    int            errors;
    int            reads_checked;

    function new();
      grid_width  = GW_RESET;
      grid_height = GH_RESET;
      foreach (board[i]) board[i] = '0;
      errors        = 0;
      reads_checked = 0;
    endfunction

    // Register values outside the legal range saturate to the nearest bound.
    function int cols_in_use();
      if (grid_width < 3) return 3;
      if (grid_width > 64) return 64;
      return grid_width;
    endfunction

    function int rows_in_use();
      if (grid_height < 3) return 3;
      if (grid_height > 32) return 32;
      return grid_height;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_GRID_WIDTH) grid_width = data[GW_W-1:0];
      else if (index == CFG_GRID_HEIGHT) grid_height = data[GH_W-1:0];
    endfunction

    // Live cells among the eight neighbors, wrapping at the edges of the area.
    function int live_around(int cx, int cy, int w, int h);
      int xl, xr, yu, yd;
      xl = (cx == 0) ? w - 1 : cx - 1;
      xr = (cx + 1 == w) ? 0 : cx + 1;
      yu = (cy == 0) ? h - 1 : cy - 1;
      yd = (cy + 1 == h) ? 0 : cy + 1;
      return board[yu][xl] + board[yu][cx] + board[yu][xr] + board[cy][xl] +
             board[cy][xr] + board[yd][xl] + board[yd][cx] + board[yd][xr];
    endfunction

    // Cells outside the area are carried over untouched.
    function void step_generation(int w, int h);
      bit [63:0] next_board [32];
      int n;
      next_board = board;
      for (int cy = 0; cy < h; cy++) begin
        for (int cx = 0; cx < w; cx++) begin
          n = live_around(cx, cy, w, h);
          if (board[cy][cx]) next_board[cy][cx] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
          else next_board[cy][cx] = (n == BIRTH_COUNT);
        end
      end
      board = next_board;
    endfunction

    function void note_request(logic [ACTION_W-1:0] action, logic [X_W-1:0] x,
                               logic [Y_W-1:0] y, logic alive);
      int w, h;
      cell_report_t rep;
      w = cols_in_use();
      h = rows_in_use();
      case (action)
        ACT_WRITE: begin
          if (x < w && y < h) board[y][x] = alive;
        end
        ACT_READ: begin
          if (x < w && y < h) begin
            rep.cell_alive     = board[y][x];
            rep.neighbor_count = CNT_W'(live_around(x, y, w, h));
          end else begin
            rep.cell_alive     = 1'b0;
            rep.neighbor_count = '0;
          end
          pending_reads = {pending_reads, rep};
        end
        ACT_ADVANCE: begin
          step_generation(w, h);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_read(logic cell_alive, logic [CNT_W-1:0] neighbor_count);
      cell_report_t want;
      reads_checked++;
      if (pending_reads.size() == 0) begin
        $error("unexpected result: cell_alive %0d neighbor_count %0d",
               cell_alive, neighbor_count);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      if (cell_alive !== want.cell_alive) begin
        $error("cell_alive: expected %0d, actual %0d", want.cell_alive, cell_alive);
        errors++;
      end
      if (neighbor_count !== want.neighbor_count) begin
        $error("neighbor_count: expected %0d, actual %0d",
               want.neighbor_count, neighbor_count);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_reads.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lgs_req_if req_ch ();
  lgs_rsp_if rsp_ch ();
  lgs_cfg_if cfg_ch ();

  life_generation_step u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  life_board_predictor board_model = new();

  // When set, the request side sends back to back.
  bit sender_calm;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every input is known from time zero. Reset starts asserted.
  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_WRITE;
    req_ch.x     = '0;
    req_ch.y     = '0;
    req_ch.alive = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GRID_WIDTH;
    cfg_ch.data  = '0;
    rsp_ch.ready = 1'b0;
  end

  // Any handshake on any channel counts as progress. A long silence means the
  // block has hung, so the run ends as a failure.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result monitor: each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board_model.check_read(rsp_ch.cell_alive, rsp_ch.neighbor_count);
  end

  // Result receiver. It stalls for a random number of cycles before each
  // result, with calm stretches where it stays ready. Once, after a hundred
  // results, it holds off for a long stretch so the block backs up and stops
  // taking items.
  initial begin
    int  gap;
    bit  calm;
    bit  long_hold_done;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (!long_hold_done && board_model.reads_checked >= 100) begin
        long_hold_done = 1'b1;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Offers one item after a random gap and waits until the block takes it.
  // Valid stays high after acceptance so that back to back items need no
  // second assignment in the same step.
  task automatic send_item(logic [ACTION_W-1:0] action, logic [X_W-1:0] x,
                           logic [Y_W-1:0] y, logic alive);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= action;
    req_ch.x      <= x;
    req_ch.y      <= y;
    req_ch.alive  <= alive;
    do @(posedge clk); while (!req_ch.ready);
    board_model.note_request(action, x, y, alive);
  endtask

  // Waits until every predicted result has arrived. Writes and advances leave
  // nothing to wait for, so a full sweep's worth of cycles follows.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board_model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board_model.set_register(index, data);
    @(posedge clk);
  endtask

  // Mostly coordinates inside the area in use, sometimes anywhere in the
  // field range so that out of area writes and reads keep coming.
  task automatic send_random_item();
    int               pick;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [ACTION_W-1:0] action;
    pick = $urandom_range(0, 99);
    if (pick < 50) action = ACT_WRITE;
    else if (pick < 85) action = ACT_READ;
    else if (pick < 95) action = ACT_ADVANCE;
    else action = ACT_UNUSED;
    if ($urandom_range(0, 99) < 85) begin
      x = X_W'($urandom_range(0, board_model.cols_in_use() - 1));
      y = Y_W'($urandom_range(0, board_model.rows_in_use() - 1));
    end else begin
      x = X_W'($urandom_range(0, 63));
      y = Y_W'($urandom_range(0, 31));
    end
    send_item(action, x, y, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned w_values [6];
    int unsigned h_values [6];
    w_values = '{0, 127, 64, 3, 2, 65};
    h_values = '{0, 63, 32, 3, 33, 1};
    sender_calm = 1'b0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset size of 40 by 20. Three live cells around
    // the corners make cell (0,0) see exactly three neighbors across both
    // wrap edges, so it is born on the next generation.
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_WRITE, 39, 19, 1);
    send_item(ACT_WRITE, 0, 19, 1);
    send_item(ACT_WRITE, 39, 0, 1);
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_READ, 39, 19, 0);
    send_item(ACT_ADVANCE, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0);
    // Writes just past the area and at the field maximum must be ignored,
    // and reads there return zeros.
    send_item(ACT_WRITE, 40, 0, 1);
    send_item(ACT_WRITE, 5, 20, 1);
    send_item(ACT_WRITE, 63, 31, 1);
    send_item(ACT_READ, 40, 0, 0);
    send_item(ACT_READ, 63, 31, 0);
    send_item(ACT_READ, 5, 20, 0);
    // The unused action produces nothing.
    send_item(ACT_UNUSED, 63, 31, 1);
    send_item(ACT_WRITE, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_WRITE, 38, 18, 1);
    send_item(ACT_ADVANCE, 0, 0, 0);
    send_item(ACT_READ, 38, 19, 0);
    send_item(ACT_READ, 39, 19, 0);
    send_item(ACT_READ, 39, 18, 0);

    // Random phases. The first six sizes hit the saturation points and the
    // exact bounds; the rest are drawn from the legal range. Shrinking after
    // a large area leaves cells outside that must survive unchanged.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase < 6) begin
        write_register(CFG_GRID_WIDTH, CFG_DATA_W'(w_values[phase]));
        write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(h_values[phase]));
      end else begin
        write_register(CFG_GRID_WIDTH, CFG_DATA_W'($urandom_range(3, 64)));
        write_register(CFG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(3, 32)));
      end
      sender_calm = (phase % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, mid phase, the sender stops until every result is back.
        if (phase == 4 && n == PHASE_ITEMS / 2) drain();
        send_random_item();
      end
    end

    drain();
    if (board_model.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lgs_pkg.sv
design/lgs_if.sv
design/lgs_row_cell.sv
design/lgs_rule_unit.sv
design/life_generation_step.sv
sim/testbench.sv
